@@ rtl/pcag_pkg.sv @@
// shared types and constants for the priority class admission gate
// no dependencies; used by the top level
package pcag_pkg;

  localparam int ENTRIES       = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ENTRIES + 1);

  // field widths of the stream payloads
  localparam int ENTRY_W = 4;
  localparam int PRIO_W  = 16;
  localparam int MASK_W  = 16;
  localparam int LEVEL_W = 16;
  localparam int RUN_W   = 5;

  // event kinds carried in the input tuser bit
  localparam logic CMD_WAIT   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [1:0] {
    STAT_IDLE   = 2'd0,
    STAT_WAIT   = 2'd1,
    STAT_ACTIVE = 2'd2,
    STAT_DONE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

@@ rtl/priority_class_admission_gate_core.sv @@
// top level of the priority class admission gate: event sequencer, entry table, level scan
// depends on pcag_pkg and pcag_ram
//
// Each accepted event (wait or finish on one requester entry) is handled by a sequencer
// that walks the entry table once through the level ram read port, one entry per cycle,
// with a single shared magnitude comparator. The walk either finds the lowest waiting level
// together with all entries tied at it, or matches waiting entries against the level already
// granted. After the walk, an event's result is loaded into the output register once the
// output slot is free, and the next event can be taken once that is done. An entry index
// outside the table skips the walk and goes straight to the output state. in_tready is low
// while an event is in progress; the result sits in an output register, so the next event
// is taken while a result waits on out_tready. The level store is not cleared after reset:
// a level is read only for waiting entries, and a wait always writes it first.
module priority_class_admission_gate_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] entry, [19:4] priority_req, [23:20] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] admitted_mask, [31:16] granted_level,
                                  // [36:32] running_count, [39:37] zero
  output logic        out_tuser   // [0] level_valid
);

  import pcag_pkg::*;

  state_t                   state_r, state_nxt;
  status_t                  status_r   [ENTRIES];
  status_t                  status_nxt [ENTRIES];
  logic [PRIORITY_BITS-1:0] cur_level_r, cur_level_nxt;
  logic                     cur_valid_r, cur_valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  // scan control and accumulators
  logic [IDX_W:0]           issue_cnt_r, issue_cnt_nxt;
  logic                     proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]         proc_idx_r, proc_idx_nxt;
  logic                     find_min_r, find_min_nxt;
  logic                     found_r, found_nxt;
  logic [PRIORITY_BITS-1:0] best_r, best_nxt;
  logic [ENTRIES-1:0]       mask_r, mask_nxt;
  logic [CNT_W-1:0]         match_cnt_r, match_cnt_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]        out_mask_r, out_mask_nxt;
  logic [LEVEL_W-1:0]       out_level_r, out_level_nxt;
  logic                     out_lvalid_r, out_lvalid_nxt;
  logic [RUN_W-1:0]         out_run_r, out_run_nxt;

  // input field unpacking
  logic                     in_cmd;
  logic [ENTRY_W-1:0]       in_entry;
  logic [PRIO_W-1:0]        in_prio;
  logic                     in_xfer;
  logic                     entry_ok;
  logic [IDX_W-1:0]         entry_idx;
  logic [CNT_W-1:0]         count_dec;

  // ram ports
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [PRIORITY_BITS-1:0] ram_rdata;

  // shared comparator
  logic [PRIORITY_BITS-1:0] cmp_ref;
  logic                     cmp_lt, cmp_eq;
  logic                     hit_wait;
  logic [ENTRIES-1:0]       hit_bit;

  // finalize values
  logic                     fin_valid;
  logic [PRIORITY_BITS-1:0] fin_level;
  logic [CNT_W:0]           fin_sum;
  logic [CNT_W-1:0]         fin_count;
  logic                     out_free;

  assign in_cmd    = in_tuser;
  assign in_entry  = in_tdata[3:0];
  assign in_prio   = in_tdata[19:4];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign entry_ok  = (32'(in_entry) < ENTRIES);
  assign entry_idx = IDX_W'(in_entry);
  assign count_dec = (count_r != '0) ? count_r - CNT_W'(1) : count_r;
  assign out_free  = !out_valid_r || out_tready;

  // level store, written on a wait event, read by the scan
  assign ram_we    = in_xfer && entry_ok && (in_cmd == CMD_WAIT);
  assign ram_raddr = issue_cnt_r[IDX_W-1:0];

  pcag_ram #(
    .WIDTH (PRIORITY_BITS),
    .DEPTH (ENTRIES)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (entry_idx),
    .wr_data (PRIORITY_BITS'(in_prio)),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // shared compare unit against running minimum or granted level
  assign cmp_ref  = find_min_r ? best_r : cur_level_r;
  assign cmp_lt   = (ram_rdata < cmp_ref);
  assign cmp_eq   = (ram_rdata == cmp_ref);
  assign hit_wait = proc_vld_r && (status_r[proc_idx_r] == STAT_WAIT);
  assign hit_bit  = ENTRIES'(1) << proc_idx_r;

  // resulting grant and running count
  assign fin_valid = find_min_r ? found_r : cur_valid_r;
  assign fin_level = find_min_r ? (found_r ? best_r : '0) : cur_level_r;
  assign fin_sum   = {1'b0, count_r} + {1'b0, match_cnt_r};
  assign fin_count = (fin_sum > (CNT_W + 1)'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                       : fin_sum[CNT_W-1:0];

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cur_level_nxt  = cur_level_r;
    cur_valid_nxt  = cur_valid_r;
    count_nxt      = count_r;
    issue_cnt_nxt  = issue_cnt_r;
    proc_vld_nxt   = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    find_min_nxt   = find_min_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    mask_nxt       = mask_r;
    match_cnt_nxt  = match_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_mask_nxt   = out_mask_r;
    out_level_nxt  = out_level_r;
    out_lvalid_nxt = out_lvalid_r;
    out_run_nxt    = out_run_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          issue_cnt_nxt = '0;
          found_nxt     = 1'b0;
          best_nxt      = '0;
          mask_nxt      = '0;
          match_cnt_nxt = '0;
          find_min_nxt  = 1'b0;
          if (!entry_ok) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
            if (in_cmd == CMD_WAIT) begin
              status_nxt[entry_idx] = STAT_WAIT;
              if (count_r == '0) begin
                find_min_nxt = 1'b1;
              end else if (!cur_valid_r) begin
                cur_level_nxt = PRIORITY_BITS'(in_prio);
                cur_valid_nxt = 1'b1;
              end
            end else begin
              status_nxt[entry_idx] = STAT_DONE;
              count_nxt             = count_dec;
              find_min_nxt          = (count_dec == '0);
            end
          end
        end
      end

      ST_SCAN: begin
        // issue one ram read per cycle
        if (issue_cnt_r < (IDX_W + 1)'(ENTRIES)) begin
          issue_cnt_nxt = issue_cnt_r + (IDX_W + 1)'(1);
          proc_vld_nxt  = 1'b1;
          proc_idx_nxt  = issue_cnt_r[IDX_W-1:0];
        end
        // process the entry whose level just came back
        if (hit_wait) begin
          if (find_min_r) begin
            if (!found_r || cmp_lt) begin
              found_nxt     = 1'b1;
              best_nxt      = ram_rdata;
              mask_nxt      = hit_bit;
              match_cnt_nxt = CNT_W'(1);
            end else if (cmp_eq) begin
              mask_nxt      = mask_r | hit_bit;
              match_cnt_nxt = match_cnt_r + CNT_W'(1);
            end
          end else if (cur_valid_r && cmp_eq) begin
            mask_nxt      = mask_r | hit_bit;
            match_cnt_nxt = match_cnt_r + CNT_W'(1);
          end
        end
        if (proc_vld_r && (proc_idx_r == IDX_W'(ENTRIES - 1))) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        // commit admissions and load the result once the output slot is free
        if (out_free) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (mask_r[i]) begin
              status_nxt[i] = STAT_ACTIVE;
            end
          end
          cur_valid_nxt  = fin_valid;
          cur_level_nxt  = fin_level;
          count_nxt      = fin_count;
          out_valid_nxt  = 1'b1;
          out_mask_nxt   = MASK_W'(mask_r);
          out_lvalid_nxt = fin_valid;
          out_level_nxt  = fin_valid ? LEVEL_W'(fin_level) : '0;
          out_run_nxt    = RUN_W'(fin_count);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_level_r <= '0;
      cur_valid_r <= 1'b0;
      count_r     <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        status_r[i] <= STAT_IDLE;
      end
    end else begin
      state_r     <= state_nxt;
      cur_level_r <= cur_level_nxt;
      cur_valid_r <= cur_valid_nxt;
      count_r     <= count_nxt;
      proc_vld_r  <= proc_vld_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // scan accumulators and output payload
  always_ff @(posedge clk) begin
    issue_cnt_r  <= issue_cnt_nxt;
    proc_idx_r   <= proc_idx_nxt;
    find_min_r   <= find_min_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    mask_r       <= mask_nxt;
    match_cnt_r  <= match_cnt_nxt;
    out_mask_r   <= out_mask_nxt;
    out_level_r  <= out_level_nxt;
    out_lvalid_r <= out_lvalid_nxt;
    out_run_r    <= out_run_nxt;
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_lvalid_r;
  assign out_tdata  = {3'b000, out_run_r, out_level_r, out_mask_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("active count above table size");

  a_mask_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> ($countones(mask_r) == 32'(match_cnt_r)))
    else $error("admission mask and match count disagree");

  a_no_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[31:16] == '0))
    else $error("granted level nonzero with no level granted");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before event completed");

endmodule

@@ rtl/pcag_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module pcag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
